// File: hdl/calendar_clock_with_alarm_defines.svh
// ---------------------------------------------------------------------------
// Calendar clock assertion macros
// Shared concurrent assertion forms for the calendar clock checkers.
// ---------------------------------------------------------------------------
`ifndef CALENDAR_CLOCK_WITH_ALARM_DEFINES_SVH
`define CALENDAR_CLOCK_WITH_ALARM_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CCA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CCA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/cca_pkg.sv
// ---------------------------------------------------------------------------
// Calendar clock package
// Beat types, function codes and counter limits for the calendar clock.
// ---------------------------------------------------------------------------
package cca_pkg;

	// Function codes carried by an input beat.
	typedef enum logic [1:0] {
		FUNC_TICK  = 2'd0,
		FUNC_LOAD  = 2'd1,
		FUNC_CLEAR = 2'd2
	} cca_func_t;

	// Register indexes on the configuration port (word address bit 2).
	localparam int unsigned PADDR_W              = 3;
	localparam logic        REG_IDX_ALARM_HOUR   = 1'b0;
	localparam logic        REG_IDX_ALARM_MINUTE = 1'b1;

	// Counter limits.
	localparam logic [5:0]  SEC_LAST      = 6'd59;
	localparam logic [5:0]  MIN_LAST      = 6'd59;
	localparam logic [4:0]  HOUR_LAST     = 5'd23;
	localparam logic [3:0]  MONTH_LAST    = 4'd12;
	localparam logic [15:0] YEAR_LAST     = 16'hFFFF;
	localparam logic [8:0]  YEAR_REM_LAST = 9'd399;

	// Month codes with special lengths.
	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_APR = 4'd4;
	localparam logic [3:0] MONTH_JUN = 4'd6;
	localparam logic [3:0] MONTH_SEP = 4'd9;
	localparam logic [3:0] MONTH_NOV = 4'd11;

	localparam logic [4:0] LEN_LONG  = 5'd31;
	localparam logic [4:0] LEN_SHORT = 5'd30;
	localparam logic [4:0] LEN_LEAP  = 5'd29;
	localparam logic [4:0] LEN_FEB   = 5'd28;

	// Year remainders within a 400-year cycle that are centuries but not leap.
	localparam logic [8:0] REM_CENT1 = 9'd100;
	localparam logic [8:0] REM_CENT2 = 9'd200;
	localparam logic [8:0] REM_CENT3 = 9'd300;

	// Reciprocal of 400 scaled by 2^25; exact quotient for every 16-bit year.
	localparam int unsigned QUOT_W      = 8;
	localparam int unsigned RECIP_SHIFT = 25;
	localparam int unsigned PROD_W      = 33;
	localparam logic [16:0] RECIP_400   = 17'd83887;

	// Reset values.
	localparam logic [15:0] RST_YEAR     = 16'd2000;
	localparam logic [8:0]  RST_YEAR_REM = 9'd0;
	localparam logic [3:0]  RST_MONTH    = 4'd1;
	localparam logic [4:0]  RST_DATE     = 5'd1;

	typedef struct packed {
		logic [1:0]  func;
		logic [15:0] load_year;
		logic [3:0]  load_month;
		logic [4:0]  load_date;
		logic [4:0]  load_hour;
		logic [5:0]  load_minute;
		logic [5:0]  load_second;
	} cca_item_t;

	typedef struct packed {
		logic [15:0] year;
		logic [3:0]  month;
		logic [4:0]  date;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic        alarm_fired;
		logic        alarm_active;
	} cca_result_t;

	// Clock state, with the year's remainder modulo 400 kept alongside it.
	typedef struct packed {
		logic [15:0] year;
		logic [8:0]  year_rem;
		logic [3:0]  month;
		logic [4:0]  date;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic        alarm_latched;
	} cca_time_t;

endpackage

// File: hdl/cca_step.sv
// ---------------------------------------------------------------------------
// Calendar clock step
// Works out the clock state that follows one beat: a tick, a load or a clear.
// ---------------------------------------------------------------------------
module cca_step (
	input  cca_pkg::cca_time_t             cur,
	input  cca_pkg::cca_item_t             item,
	input  logic [cca_pkg::QUOT_W-1:0]     quot,
	input  logic [4:0]                     alarm_hour,
	input  logic [5:0]                     alarm_minute,
	output cca_pkg::cca_time_t             nxt,
	output logic                           fired
);

	logic       leap;
	logic [4:0] month_len;
	logic [15:0] quot_x400;
	cca_pkg::cca_time_t ticked;

	// Leap year from the remainder modulo 400.
	assign leap = (cur.year_rem[1:0] == 2'b00) &&
		(cur.year_rem != cca_pkg::REM_CENT1) &&
		(cur.year_rem != cca_pkg::REM_CENT2) &&
		(cur.year_rem != cca_pkg::REM_CENT3);

	// Length of the current month.
	always_comb begin
		case (cur.month)
			cca_pkg::MONTH_APR, cca_pkg::MONTH_JUN,
			cca_pkg::MONTH_SEP, cca_pkg::MONTH_NOV: begin
				month_len = cca_pkg::LEN_SHORT;
			end
			cca_pkg::MONTH_FEB: begin
				month_len = leap ? cca_pkg::LEN_LEAP : cca_pkg::LEN_FEB;
			end
			default: begin
				month_len = cca_pkg::LEN_LONG;
			end
		endcase
	end

	// One second forward, with carries through to the year.
	always_comb begin
		ticked = cur;
		if (cur.second < cca_pkg::SEC_LAST) begin
			ticked.second = cur.second + 6'd1;
		end else begin
			ticked.second = '0;
			if (cur.minute < cca_pkg::MIN_LAST) begin
				ticked.minute = cur.minute + 6'd1;
			end else begin
				ticked.minute = '0;
				if (cur.hour < cca_pkg::HOUR_LAST) begin
					ticked.hour = cur.hour + 5'd1;
				end else begin
					ticked.hour = '0;
					if (cur.date < month_len) begin
						ticked.date = cur.date + 5'd1;
					end else begin
						ticked.date = cca_pkg::RST_DATE;
						if (cur.month < cca_pkg::MONTH_LAST) begin
							ticked.month = cur.month + 4'd1;
						end else begin
							ticked.month = cca_pkg::RST_MONTH;
							ticked.year  = cur.year + 16'd1;
							if ((cur.year == cca_pkg::YEAR_LAST) ||
								(cur.year_rem == cca_pkg::YEAR_REM_LAST)) begin
								ticked.year_rem = '0;
							end else begin
								ticked.year_rem = cur.year_rem + 9'd1;
							end
						end
					end
				end
			end
		end
	end

	// Quotient times 400 by shifts and adds; the load remainder follows from it.
	assign quot_x400 = (16'(quot) << 8) + (16'(quot) << 7) + (16'(quot) << 4);

	// Select the action of the beat and check the alarm after a tick.
	always_comb begin
		nxt   = cur;
		fired = 1'b0;
		case (item.func)
			cca_pkg::FUNC_TICK: begin
				nxt = ticked;
				if ((ticked.second == '0) && (ticked.minute == alarm_minute) &&
					(ticked.hour == alarm_hour)) begin
					fired             = 1'b1;
					nxt.alarm_latched = 1'b1;
				end
			end
			cca_pkg::FUNC_LOAD: begin
				nxt.year     = item.load_year;
				nxt.year_rem = 9'(item.load_year - quot_x400);
				nxt.month    = item.load_month;
				nxt.date     = item.load_date;
				nxt.hour     = item.load_hour;
				nxt.minute   = item.load_minute;
				nxt.second   = item.load_second;
			end
			cca_pkg::FUNC_CLEAR: begin
				nxt.alarm_latched = 1'b0;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

// File: hdl/calendar_clock_with_alarm.sv
// ---------------------------------------------------------------------------
// Calendar clock with alarm
// Second-resolution calendar with Gregorian leap years and a latched alarm.
// ---------------------------------------------------------------------------
//  channel  | valid         | stall         | payload
//  ---------+---------------+---------------+-------------------------------
//  input    | item_valid    | item_stall    | item   (cca_item_t)
//  output   | result_valid  | result_stall  | result (cca_result_t)
//  config   | psel, penable | pready (high) | paddr, pwdata, prdata
//
// A beat is taken into the input register and passes the step logic into the
// result register once that is free or being taken, and its result is offered
// from there; one beat per cycle is taken while the input does not stall.
// The input register also holds the year divided by 400 for a load beat.
// Reset returns the clock to midnight, 1 January 2000, with the alarm clear.
// A stalled result holds; the input stalls only while both stages are full and
// the result is stalled.
// ---------------------------------------------------------------------------
module calendar_clock_with_alarm (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  cca_pkg::cca_item_t               item,
	output logic                             result_valid,
	input  logic                             result_stall,
	output cca_pkg::cca_result_t             result,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [cca_pkg::PADDR_W-1:0]      paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);

	logic                          valid_s1;
	cca_pkg::cca_item_t            item_s1;
	logic [cca_pkg::QUOT_W-1:0]    quot_s1;
	logic                          result_valid_s2;
	cca_pkg::cca_result_t          result_s2;
	cca_pkg::cca_time_t            time_q;
	cca_pkg::cca_time_t            time_nxt;
	logic                          fired;
	logic [4:0]                    alarm_hour_q;
	logic [5:0]                    alarm_minute_q;
	logic                          accept;
	logic                          advance;
	logic                          cfg_write;
	logic [cca_pkg::PROD_W-1:0]    recip_prod;

	// Handshake: the step stage moves when the result register is free.
	assign advance    = valid_s1 && (!result_valid_s2 || !result_stall);
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;

	// Year divided by 400 through the reciprocal, for a load beat.
	assign recip_prod = cca_pkg::PROD_W'(item.load_year) *
		cca_pkg::PROD_W'(cca_pkg::RECIP_400);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
			quot_s1 <= recip_prod[cca_pkg::RECIP_SHIFT +: cca_pkg::QUOT_W];
		end
	end

	cca_step u_step (
		.cur          (time_q),
		.item         (item_s1),
		.quot         (quot_s1),
		.alarm_hour   (alarm_hour_q),
		.alarm_minute (alarm_minute_q),
		.nxt          (time_nxt),
		.fired        (fired)
	);

	// Clock state, updated as each beat leaves the step stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q.year          <= cca_pkg::RST_YEAR;
			time_q.year_rem      <= cca_pkg::RST_YEAR_REM;
			time_q.month         <= cca_pkg::RST_MONTH;
			time_q.date          <= cca_pkg::RST_DATE;
			time_q.hour          <= '0;
			time_q.minute        <= '0;
			time_q.second        <= '0;
			time_q.alarm_latched <= 1'b0;
		end else if (advance) begin
			time_q <= time_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_s2 <= 1'b0;
		end else if (advance) begin
			result_valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			result_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2.year         <= time_nxt.year;
			result_s2.month        <= time_nxt.month;
			result_s2.date         <= time_nxt.date;
			result_s2.hour         <= time_nxt.hour;
			result_s2.minute       <= time_nxt.minute;
			result_s2.second       <= time_nxt.second;
			result_s2.alarm_fired  <= fired;
			result_s2.alarm_active <= time_nxt.alarm_latched;
		end
	end

	assign result_valid = result_valid_s2;
	assign result       = result_s2;

	// Alarm registers on the configuration port.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm_hour_q   <= '0;
			alarm_minute_q <= '0;
		end else if (cfg_write) begin
			case (paddr[2])
				cca_pkg::REG_IDX_ALARM_HOUR: begin
					alarm_hour_q <= pwdata[4:0];
				end
				cca_pkg::REG_IDX_ALARM_MINUTE: begin
					alarm_minute_q <= pwdata[5:0];
				end
				default: begin
					alarm_hour_q <= alarm_hour_q;
				end
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (paddr[2])
			cca_pkg::REG_IDX_ALARM_HOUR: begin
				prdata = 32'(alarm_hour_q);
			end
			cca_pkg::REG_IDX_ALARM_MINUTE: begin
				prdata = 32'(alarm_minute_q);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

endmodule

// File: hdl/cca_checker.sv
// ---------------------------------------------------------------------------
// Calendar clock checker
// Port-level assertions on the calendar clock, attached by a bind.
// ---------------------------------------------------------------------------
`include "calendar_clock_with_alarm_defines.svh"

module cca_checker (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_stall,
	input  logic                   result_valid,
	input  logic                   result_stall,
	input  cca_pkg::cca_result_t   result
);

	// A stalled result beat stays offered.
	`CCA_ASSERT_NEXT(a_result_held, clk, arst_n, result_valid && result_stall, result_valid, "result beat dropped while stalled")

	// A stalled result beat keeps its payload.
	`CCA_ASSERT_NEXT(a_result_stable, clk, arst_n, result_valid && result_stall, $stable(result), "result payload changed while stalled")

	// With the output empty the pipeline always has room for a new beat.
	`CCA_ASSERT_SAME(a_no_idle_stall, clk, arst_n, !result_valid, !item_stall, "input stalled with the output empty")

	// An alarm fires only on the zero second and always latches.
	`CCA_ASSERT_SAME(a_fire_latches, clk, arst_n, result_valid && result.alarm_fired, result.alarm_active && (result.second == 6'd0), "alarm fired without latching on second zero")

endmodule

bind calendar_clock_with_alarm cca_checker u_cca_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Calendar clock with alarm testbench
// Drives tick, load, clear and unused beats into the calendar clock, keeps its
// own copy of the calendar and the alarm registers, and checks every result
// beat field by field in order. The alarm registers are set over the APB-style
// port between phases, and both channels idle and stall at random.
// ---------------------------------------------------------------------------
module tb_top;
	import cca_pkg::*;

	localparam int CLK_HALF      = 5;
	localparam int RESET_CYCLES  = 9;
	localparam int CYCLE_LIMIT   = 100000;
	localparam int IDLE_PERCENT  = 36;
	localparam int HOLD_CYCLES   = 80;
	localparam int SETTLE_CYCLES = 6;
	localparam int RANDOM_BEATS  = 420;
	localparam int PHASES        = 5;

	// The function code the block leaves unused.
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	typedef struct {
		logic [15:0] year;
		logic [3:0]  month;
		logic [4:0]  date;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic        alarm_latched;
	} calendar_t;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 item_valid   = 1'b0;
	logic                 item_stall;
	cca_item_t            item         = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	cca_result_t          result;
	logic                 psel         = 1'b0;
	logic                 penable      = 1'b0;
	logic                 pwrite       = 1'b0;
	logic [PADDR_W-1:0]   paddr        = '0;
	logic [31:0]          pwdata       = '0;
	logic [31:0]          prdata;
	logic                 pready;

	// Predicted calendar and alarm settings.
	calendar_t   cal = '{year: RST_YEAR, month: RST_MONTH, date: RST_DATE, hour: '0,
		minute: '0, second: '0, alarm_latched: 1'b0};
	logic [4:0]  alarm_hour_setting   = '0;
	logic [5:0]  alarm_minute_setting = '0;
	cca_result_t pending_results[$];

	// Run control and tallies.
	logic idle_on         = 1'b1;
	int   holds_requested = 0;
	int   holds_served    = 0;
	int   hold_left       = 0;
	int   mismatches      = 0;
	int   beats_sent      = 0;
	int   results_checked = 0;
	int   alarms_expected = 0;
	int   reg_writes      = 0;
	int   cycle_count     = 0;

	calendar_clock_with_alarm dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #CLK_HALF clk = ~clk;

	// Advance the predicted calendar by one input beat and return what the
	// block should report afterwards.
	function automatic cca_result_t step_calendar(input cca_item_t beat);
		cca_result_t res;
		logic [4:0]  month_len;
		logic        leap;
		logic        fired;
		fired = 1'b0;
		case (beat.func)
		FUNC_TICK: begin
			if (cal.second < SEC_LAST) begin
				cal.second++;
			end else begin
				cal.second = '0;
				if (cal.minute < MIN_LAST) begin
					cal.minute++;
				end else begin
					cal.minute = '0;
					if (cal.hour < HOUR_LAST) begin
						cal.hour++;
					end else begin
						cal.hour = '0;
						// Gregorian rule: centuries are leap only every fourth one.
						if (cal.year % 100 == 0) begin
							leap = (cal.year % 400 == 0);
						end else begin
							leap = (cal.year % 4 == 0);
						end
						case (cal.month)
						MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: month_len = LEN_SHORT;
						MONTH_FEB: month_len = leap ? LEN_LEAP : LEN_FEB;
						default: month_len = LEN_LONG;
						endcase
						if (cal.date >= month_len) begin
							cal.date = 5'd1;
							if (cal.month >= MONTH_LAST) begin
								cal.month = 4'd1;
								cal.year  = cal.year + 16'd1;
							end else begin
								cal.month++;
							end
						end else begin
							cal.date++;
						end
					end
				end
			end
			if (cal.second == '0 && cal.minute == alarm_minute_setting &&
					cal.hour == alarm_hour_setting) begin
				fired             = 1'b1;
				cal.alarm_latched = 1'b1;
			end
		end
		FUNC_LOAD: begin
			cal.year   = beat.load_year;
			cal.month  = beat.load_month;
			cal.date   = beat.load_date;
			cal.hour   = beat.load_hour;
			cal.minute = beat.load_minute;
			cal.second = beat.load_second;
		end
		FUNC_CLEAR: begin
			cal.alarm_latched = 1'b0;
		end
		default: begin
		end
		endcase
		res.year         = cal.year;
		res.month        = cal.month;
		res.date         = cal.date;
		res.hour         = cal.hour;
		res.minute       = cal.minute;
		res.second       = cal.second;
		res.alarm_fired  = fired;
		res.alarm_active = cal.alarm_latched;
		return res;
	endfunction

	// A beat with random payload bits and the given function code.
	function automatic cca_item_t random_beat(input logic [1:0] func);
		logic [63:0] raw;
		cca_item_t   beat;
		raw       = {$urandom(), $urandom()};
		beat      = raw[$bits(cca_item_t)-1:0];
		beat.func = func;
		return beat;
	endfunction

	function automatic cca_item_t load_beat(input logic [15:0] year, input logic [3:0] month,
			input logic [4:0] date, input logic [4:0] hour, input logic [5:0] minute,
			input logic [5:0] second);
		cca_item_t beat;
		beat             = random_beat(FUNC_LOAD);
		beat.load_year   = year;
		beat.load_month  = month;
		beat.load_date   = date;
		beat.load_hour   = hour;
		beat.load_minute = minute;
		beat.load_second = second;
		return beat;
	endfunction

	// Offer one input beat, with random idle cycles first, and record the
	// prediction once the beat is taken.
	task automatic send_beat(input cca_item_t beat);
		cca_result_t want;
		@(negedge clk);
		while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= beat;
		do @(posedge clk); while (item_stall);
		want = step_calendar(beat);
		pending_results.push_back(want);
		beats_sent++;
		if (want.alarm_fired) begin
			alarms_expected++;
		end
	endtask

	task automatic load_then_tick(input cca_item_t beat);
		send_beat(beat);
		send_beat(random_beat(FUNC_TICK));
	endtask

	// Stop offering beats and let every outstanding result drain.
	task automatic wait_idle();
		@(negedge clk);
		item_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write one alarm register, then read it back.
	task automatic write_alarm_reg(input logic idx, input logic [31:0] value);
		logic [31:0] want;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_IDX_ALARM_HOUR) begin
			alarm_hour_setting = value[4:0];
			want               = 32'(value[4:0]);
		end else begin
			alarm_minute_setting = value[5:0];
			want                 = 32'(value[5:0]);
		end
		reg_writes++;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want) begin
			mismatches++;
			$display("%0t: register %0d read back, expected %0h, actual %0h",
				$time, idx, want, prdata);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// Every result beat taken is compared with the oldest prediction.
	always @(posedge clk) begin
		cca_result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t: result beat with nothing outstanding, actual %h", $time, result);
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				check_field("year", want.year, result.year);
				check_field("month", 16'(want.month), 16'(result.month));
				check_field("date", 16'(want.date), 16'(result.date));
				check_field("hour", 16'(want.hour), 16'(result.hour));
				check_field("minute", 16'(want.minute), 16'(result.minute));
				check_field("second", 16'(want.second), 16'(result.second));
				check_field("alarm_fired", 16'(want.alarm_fired), 16'(result.alarm_fired));
				check_field("alarm_active", 16'(want.alarm_active),
					16'(result.alarm_active));
			end
		end
	end

	// Result stalls: random, or a long hold-off when one has been asked for.
	always @(negedge clk) begin
		if (hold_left == 0 && holds_served != holds_requested) begin
			hold_left = HOLD_CYCLES;
			holds_served++;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= idle_on && ($urandom_range(0, 99) < IDLE_PERCENT);
		end
	end

	// Guard against a hang.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding",
				cycle_count, pending_results.size());
			$display("Verification failed");
			$finish;
		end
	end

	// Reset behaviour, the unused code and the calendar's carry corners.
	task automatic test_calendar_edges();
		// Straight after reset an unused code and a clear just report midnight 2000.
		send_beat(random_beat(FUNC_UNUSED));
		send_beat(random_beat(FUNC_CLEAR));
		// The last second of the last year wraps to year 0 and hits the midnight alarm.
		load_then_tick(load_beat(16'hFFFF, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59));
		send_beat(random_beat(FUNC_UNUSED));
		send_beat(random_beat(FUNC_CLEAR));
		// February in a leap century, on its leap day, in a plain century and a leap year.
		load_then_tick(load_beat(16'd2000, MONTH_FEB, 5'd28, 5'd23, 6'd59, 6'd59));
		load_then_tick(load_beat(16'd2000, MONTH_FEB, 5'd29, 5'd23, 6'd59, 6'd59));
		load_then_tick(load_beat(16'd1900, MONTH_FEB, 5'd28, 5'd23, 6'd59, 6'd59));
		load_then_tick(load_beat(16'd2004, MONTH_FEB, 5'd28, 5'd23, 6'd59, 6'd59));
		// End of a thirty-day month.
		load_then_tick(load_beat(16'd2023, MONTH_APR, 5'd30, 5'd23, 6'd59, 6'd59));
		// Every load field at its widest, then every field at zero.
		load_then_tick(load_beat(16'hFFFF, 4'hF, 5'h1F, 5'h1F, 6'h3F, 6'h3F));
		load_then_tick(load_beat(16'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0));
		// Month codes past December and below January count as 31-day months.
		load_then_tick(load_beat(16'd2000, 4'd13, 5'd31, 5'd23, 6'd59, 6'd59));
		load_then_tick(load_beat(16'd0, 4'd0, 5'd31, 5'd23, 6'd59, 6'd59));
	endtask

	// Random sequences near boundaries and alarm times, over several alarm settings.
	task automatic test_random_calendar(input int total);
		int          phase;
		int          start;
		int          kind;
		int          k;
		int          year_pick;
		logic [4:0]  ah;
		logic [5:0]  am;
		logic [4:0]  lh;
		logic [5:0]  lm;
		logic [15:0] year;
		logic [3:0]  month;
		logic [31:0] upper;
		for (phase = 0; phase < PHASES; phase++) begin
			wait_idle();
			case (phase)
			0: begin
				ah = HOUR_LAST;
				am = MIN_LAST;
			end
			1: begin
				ah = '1;
				am = '1;
			end
			2: begin
				ah = '0;
				am = '0;
			end
			default: begin
				ah = 5'($urandom_range(0, HOUR_LAST));
				am = 6'($urandom_range(0, MIN_LAST));
			end
			endcase
			upper = $urandom();
			write_alarm_reg(REG_IDX_ALARM_HOUR, {upper[31:5], ah});
			upper = $urandom();
			write_alarm_reg(REG_IDX_ALARM_MINUTE, {upper[31:6], am});
			// One phase runs with no idling on either side.
			idle_on = (phase != 1);
			start   = beats_sent;
			while (beats_sent - start < total / PHASES) begin
				kind = $urandom_range(0, 99);
				if (kind < 50) begin
					// Close to the end of a day, month or year, then a few ticks.
					year_pick = $urandom_range(0, 3);
					case (year_pick)
					0: year = 16'($urandom_range(0, 16'hFFFF));
					1: year = 16'(100 * $urandom_range(1, 655) - 1 + $urandom_range(0, 2));
					2: year = 16'(4 * $urandom_range(0, 16383));
					default: year = 16'hFFFF;
					endcase
					if ($urandom_range(0, 9) == 0) begin
						month = 4'($urandom_range(0, 15));
					end else begin
						month = 4'($urandom_range(1, 12));
					end
					send_beat(load_beat(year, month, 5'($urandom_range(27, 31)),
						5'($urandom_range(22, HOUR_LAST)), 6'($urandom_range(58, MIN_LAST)),
						6'($urandom_range(55, SEC_LAST))));
					repeat ($urandom_range(1, 6)) send_beat(random_beat(FUNC_TICK));
				end else if (kind < 68) begin
					// A few seconds short of the alarm time, ticked through it.
					k = $urandom_range(1, 4);
					if (am > 0) begin
						lm = am - 6'd1;
						lh = ah;
					end else begin
						lm = MIN_LAST;
						lh = (ah > 0) ? ah - 5'd1 : HOUR_LAST;
					end
					send_beat(load_beat(16'($urandom_range(0, 16'hFFFF)),
						4'($urandom_range(1, 12)), 5'($urandom_range(1, 28)), lh, lm,
						6'(60 - k)));
					repeat (k + $urandom_range(0, 2)) send_beat(random_beat(FUNC_TICK));
					if ($urandom_range(0, 1)) begin
						send_beat(random_beat(FUNC_CLEAR));
					end
				end else if (kind < 78) begin
					send_beat(random_beat(FUNC_CLEAR));
				end else if (kind < 86) begin
					send_beat(random_beat(FUNC_UNUSED));
				end else begin
					// Any bit pattern at all in the load fields.
					send_beat(random_beat(FUNC_LOAD));
					repeat ($urandom_range(1, 3)) send_beat(random_beat(FUNC_TICK));
				end
			end
		end
		idle_on = 1'b1;
	endtask

	// The receiver holds off for a long stretch while beats keep coming, so the
	// pipeline fills and stalls its input.
	task automatic test_output_backpressure();
		int n;
		wait_idle();
		idle_on = 1'b0;
		holds_requested++;
		send_beat(load_beat(16'd2099, 4'd12, 5'd31, 5'd23, 6'd59, 6'd50));
		for (n = 0; n < 23; n++) begin
			send_beat(random_beat(FUNC_TICK));
		end
		idle_on = 1'b1;
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_calendar_edges();
		test_random_calendar(RANDOM_BEATS);
		test_output_backpressure();
		wait_idle();
		$display("Run covered %0d input beats and %0d checked results,", beats_sent,
			results_checked);
		$display("with %0d alarm firings over %0d alarm register writes.", alarms_expected,
			reg_writes);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
